// ===== rtl/core/indexed_list_engine_unit_assert.svh =====
// assertion macros for the list engine checker
`ifndef INDEXED_LIST_ENGINE_UNIT_ASSERT_SVH
`define INDEXED_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ILE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("list engine check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define ILE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("list engine check failed");

`endif

// ===== rtl/core/ile_pkg.sv =====
// types and constants of the indexed list engine
`timescale 1ns / 1ps
package ile_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int OPC_W = 3;
	localparam int POS_W = 5;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int ENTRY_W = 5;

	typedef enum logic [OPC_W-1:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_APPEND = 3'd2,
		OP_FRONT  = 3'd3,
		OP_INSERT = 3'd4,
		OP_REMOVE = 3'd5,
		OP_CLEAR  = 3'd6
	} ile_op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} ile_status_t;

	// what the cell row does
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LOAD  = 2'd1,
		CELL_PLACE = 2'd2,
		CELL_PULL  = 2'd3
	} ile_cell_mode_t;

	typedef struct packed {
		ile_cell_mode_t   mode;
		logic [IDX_W-1:0] idx;
	} ile_cell_ctrl_t;

	typedef struct packed {
		logic [OPC_W-1:0]         opcode;
		logic [POS_W-1:0]         position;
		logic signed [WORD_W-1:0] data_word;
	} ile_req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_word;
		logic [STAT_W-1:0]        status;
		logic [ENTRY_W-1:0]       entry_count;
	} ile_rsp_t;

endpackage

// ===== rtl/core/ile_cells.sv =====
// row of list cells that load, open a gap or close a gap, every cell in parallel
`timescale 1ns / 1ps
module ile_cells (
	input  logic                           clk,
	input  ile_pkg::ile_cell_ctrl_t        ctrl,
	input  logic signed [ile_pkg::WORD_W-1:0] word,
	output logic signed [ile_pkg::WORD_W-1:0] rd_word
);
	import ile_pkg::*;

	logic signed [WORD_W-1:0] cells_q [CAPACITY];
	logic signed [WORD_W-1:0] below_w [CAPACITY];
	logic signed [WORD_W-1:0] above_w [CAPACITY];

	assign rd_word = cells_q[ctrl.idx];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		// neighbor taps; the first cell's lower tap is zero, the last cell's upper tap is itself
		if (i == 0) begin : g_first
			assign below_w[i] = '0;
		end else begin : g_below
			assign below_w[i] = cells_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign above_w[i] = cells_q[i];
		end else begin : g_above
			assign above_w[i] = cells_q[i+1];
		end

		always_ff @(posedge clk) begin
			case (ctrl.mode)
				CELL_LOAD: begin
					if (ctrl.idx == IDX_W'(i))
						cells_q[i] <= word;
				end
				CELL_PLACE: begin
					if (ctrl.idx == IDX_W'(i))
						cells_q[i] <= word;
					else if (ctrl.idx < IDX_W'(i))
						cells_q[i] <= below_w[i];
				end
				CELL_PULL: begin
					if (ctrl.idx <= IDX_W'(i))
						cells_q[i] <= above_w[i];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/indexed_list_engine_unit.sv =====
// top level of the indexed list engine
`timescale 1ns / 1ps
// indexed list engine: ordered list of up to CAPACITY signed words plus a count
// request channel (req_valid / req_ready / req): one command per request,
//   read, write, append back, add front, insert at, remove at, or clear
// response channel (rsp_valid / rsp_ready / rsp): exactly one response per
//   request, in order, carrying the read word, a status and the new count
// a request goes through two registers on its way to the response:
//   the input register, then the result register
// throughput: one request per cycle while the receiver takes responses; every cell
//   shifts or loads in parallel, so insert and remove are as quick at any position
// a bad position or a full list is flagged in status and changes nothing
// reset clears the count and both valid flags; cell contents stay undefined
//   and are only ever read below the count, so no clearing pass is needed
// when the receiver stalls the result register holds, the input register
//   keeps one more request, and req_ready drops only once both are occupied
module indexed_list_engine_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  ile_pkg::ile_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ile_pkg::ile_rsp_t rsp
);
	import ile_pkg::*;

	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	// input stage
	logic     valid_s1;
	ile_req_t req_s1;

	// result stage and list count
	logic             rsp_valid_q;
	ile_rsp_t         rsp_q;
	logic [CNT_W-1:0] count_q;

	// command decode
	logic                     advance;
	logic                     fire;
	logic [CMP_W-1:0]         pos_x;
	logic [CMP_W-1:0]         cnt_x;
	logic                     in_list;
	logic                     ins_ok;
	logic                     full;
	logic signed [WORD_W-1:0] rd_word;
	logic signed [WORD_W-1:0] cell_word;
	ile_status_t              status;
	logic [CNT_W-1:0]         count_next;
	ile_cell_ctrl_t           cell_cmd;
	ile_cell_ctrl_t           cell_ctrl;

	// result register free or being emptied this cycle
	assign advance = !rsp_valid_q || rsp_ready;
	assign fire = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
	end

	// position checks against the count held before this command
	assign pos_x = CMP_W'(req_s1.position);
	assign cnt_x = CMP_W'(count_q);
	assign in_list = pos_x < cnt_x;
	assign ins_ok = pos_x <= cnt_x;
	assign full = count_q == CNT_W'(CAPACITY);

	always_comb begin
		rd_word = '0;
		status = ST_DONE;
		count_next = count_q;
		cell_cmd.mode = CELL_HOLD;
		cell_cmd.idx = pos_x[IDX_W-1:0];
		case (req_s1.opcode)
			OP_READ: begin
				if (!in_list)
					status = ST_RANGE;
				else
					rd_word = cell_word;
			end
			OP_WRITE: begin
				if (!in_list)
					status = ST_RANGE;
				else
					cell_cmd.mode = CELL_LOAD;
			end
			OP_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					cell_cmd.mode = CELL_PLACE;
					cell_cmd.idx = count_q[IDX_W-1:0];
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					cell_cmd.mode = CELL_PLACE;
					cell_cmd.idx = '0;
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_INSERT: begin
				// range test wins over the full test
				if (!ins_ok) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					cell_cmd.mode = CELL_PLACE;
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (!in_list) begin
					status = ST_RANGE;
				end else begin
					cell_cmd.mode = CELL_PULL;
					count_next = count_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				count_next = '0;
			end
			default: begin
			end
		endcase
	end

	// cells move only when the command leaves for the result register
	always_comb begin
		cell_ctrl = cell_cmd;
		if (!fire)
			cell_ctrl.mode = CELL_HOLD;
	end

	ile_cells u_cells (
		.clk     (clk),
		.ctrl    (cell_ctrl),
		.word    (req_s1.data_word),
		.rd_word (cell_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (advance)
				rsp_valid_q <= valid_s1;
			if (fire)
				count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.read_word <= rd_word;
			rsp_q.status <= status;
			rsp_q.entry_count <= ENTRY_W'(count_next);
		end
	end

endmodule

// ===== rtl/core/ile_checker.sv =====
// port-level checks of the list engine and their bind
`timescale 1ns / 1ps
`include "indexed_list_engine_unit_assert.svh"
module ile_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input ile_pkg::ile_req_t req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input ile_pkg::ile_rsp_t rsp
);
	import ile_pkg::*;

	// a stalled response holds
	`ILE_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// a failed command answers with a zero word
	`ILE_ASSERT_IMPL(a_fail_no_word, clk, arst_n, rsp_valid && rsp.status != ST_DONE, rsp.read_word == '0)

	// count never passes the capacity
	`ILE_ASSERT_IMPL(a_count_cap, clk, arst_n, rsp_valid, rsp.entry_count <= ENTRY_W'(CAPACITY))

	// a full report only comes from a full list
	`ILE_ASSERT_IMPL(a_full_count, clk, arst_n, rsp_valid && rsp.status == ST_FULL, rsp.entry_count == ENTRY_W'(CAPACITY))

endmodule

bind indexed_list_engine_unit ile_checker u_ile_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for the indexed list engine with random traffic and idling
`timescale 1ns / 1ps
module testbench;
	import ile_pkg::*;

	// opcode outside the defined set, the engine answers it without touching the list
	localparam logic [OPC_W-1:0] OP_UNUSED = 3'd7;
	localparam int CLK_HALF = 4;
	localparam int MAX_REPORTS = 10;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	ile_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	ile_rsp_t rsp;

	// shadow of the list contents and count, advanced on every accepted request
	logic [WORD_W-1:0] shadow_words [CAPACITY];
	int                shadow_count = 0;

	// responses still owed by the engine, oldest first
	ile_rsp_t owed_rsps [$];

	int error_count = 0;
	int send_idle_pct = 0;
	int rcv_stall_pct = 0;

	indexed_list_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #CLK_HALF clk = ~clk;

	// receiver side: ready drops at random, the rate is set per phase
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// open a gap at slot at (at <= count < CAPACITY) and put the word there
	function automatic void shadow_place(input int at, input logic [WORD_W-1:0] word);
		for (int i = shadow_count; i > at; i--) begin
			shadow_words[i] = shadow_words[i-1];
		end
		shadow_words[at] = word;
		shadow_count++;
	endfunction

	// apply one command to the shadow list and return the response it must give
	function automatic ile_rsp_t apply_list_command(input ile_req_t cmd);
		ile_rsp_t res;
		logic     full;
		int       pos;
		res = '0;
		res.status = ST_DONE;
		full = (shadow_count >= CAPACITY);
		pos = int'(cmd.position);
		case (cmd.opcode)
			OP_READ: begin
				if (pos >= shadow_count) begin
					res.status = ST_RANGE;
				end else begin
					res.read_word = shadow_words[pos];
				end
			end
			OP_WRITE: begin
				if (pos >= shadow_count) begin
					res.status = ST_RANGE;
				end else begin
					shadow_words[pos] = cmd.data_word;
				end
			end
			OP_APPEND: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					shadow_place(shadow_count, cmd.data_word);
				end
			end
			OP_FRONT: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					shadow_place(0, cmd.data_word);
				end
			end
			OP_INSERT: begin
				// a bad position wins over a full list
				if (pos > shadow_count) begin
					res.status = ST_RANGE;
				end else if (full) begin
					res.status = ST_FULL;
				end else begin
					shadow_place(pos, cmd.data_word);
				end
			end
			OP_REMOVE: begin
				if (pos >= shadow_count) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = pos; i + 1 < shadow_count; i++) begin
						shadow_words[i] = shadow_words[i+1];
					end
					shadow_count--;
				end
			end
			OP_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
				// unused opcode, nothing changes
			end
		endcase
		res.entry_count = shadow_count[ENTRY_W-1:0];
		return res;
	endfunction

	function automatic ile_req_t make_cmd(input logic [OPC_W-1:0] op, input int pos,
			input logic [WORD_W-1:0] word);
		ile_req_t cmd;
		cmd.opcode = op;
		cmd.position = pos[POS_W-1:0];
		cmd.data_word = word;
		return cmd;
	endfunction

	// mostly random words, now and then one of the extremes
	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(24))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [OPC_W-1:0] random_grow_op();
		case ($urandom_range(2))
			0: return OP_APPEND;
			1: return OP_FRONT;
			default: return OP_INSERT;
		endcase
	endfunction

	// random command, grow_pct steers the list toward full or toward empty
	function automatic ile_req_t choose_command(input int grow_pct);
		ile_req_t cmd;
		int       roll;
		roll = $urandom_range(99);
		if (roll < 2) begin
			cmd.opcode = OP_UNUSED;
		end else if (roll < 4) begin
			cmd.opcode = OP_CLEAR;
		end else if ($urandom_range(99) < grow_pct) begin
			cmd.opcode = random_grow_op();
		end else begin
			case ($urandom_range(2))
				0: cmd.opcode = OP_READ;
				1: cmd.opcode = OP_WRITE;
				default: cmd.opcode = OP_REMOVE;
			endcase
		end
		// mostly legal positions, some anywhere in the field
		if ($urandom_range(99) < 12) begin
			cmd.position = POS_W'($urandom_range(31));
		end else if (cmd.opcode == OP_INSERT) begin
			cmd.position = POS_W'($urandom_range(shadow_count));
		end else if (shadow_count > 0) begin
			cmd.position = POS_W'($urandom_range(shadow_count - 1));
		end else begin
			cmd.position = '0;
		end
		cmd.data_word = random_word();
		return cmd;
	endfunction

	// one request: optional idle cycles, then hold valid until accepted
	task automatic send_command(input ile_req_t cmd);
		bit       lowered;
		ile_rsp_t due_rsp;
		lowered = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			if (!lowered) begin
				req_valid <= 1'b0;
				lowered = 1'b1;
			end
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= cmd;
		// ready seen at the falling edge holds through the next rising edge
		do @(negedge clk); while (!req_ready);
		@(posedge clk);
		due_rsp = apply_list_command(cmd);
		owed_rsps.insert(owed_rsps.size(), due_rsp);
	endtask

	// stop sending and let every owed response come back
	task automatic wait_for_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (owed_rsps.size() != 0) @(posedge clk);
	endtask

	task automatic note_failure(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	// response check, sampled at the falling edge ahead of the accepting edge
	always @(negedge clk) begin : check_responses
		ile_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (owed_rsps.size() == 0) begin
				note_failure($sformatf("response with none owed: word %h status %0d count %0d",
					rsp.read_word, rsp.status, rsp.entry_count));
			end else begin
				want = owed_rsps.pop_front();
				if (rsp.read_word !== want.read_word) begin
					note_failure($sformatf("read_word: expected %h got %h",
						want.read_word, rsp.read_word));
				end
				if (rsp.status !== want.status) begin
					note_failure($sformatf("status: expected %0d got %0d",
						want.status, rsp.status));
				end
				if (rsp.entry_count !== want.entry_count) begin
					note_failure($sformatf("entry_count: expected %0d got %0d",
						want.entry_count, rsp.entry_count));
				end
			end
		end
	end

	// edges of an empty list, every opcode, inserts and removes at both ends
	task automatic test_directed();
		send_command(make_cmd(OP_READ, 0, 32'h1));
		send_command(make_cmd(OP_WRITE, 0, 32'h2));
		send_command(make_cmd(OP_REMOVE, 0, 32'h0));
		send_command(make_cmd(OP_INSERT, 1, 32'h3));
		send_command(make_cmd(OP_CLEAR, 0, 32'h0));
		send_command(make_cmd(OP_UNUSED, 0, 32'h0));
		send_command(make_cmd(OP_INSERT, 0, 32'h8000_0000));
		send_command(make_cmd(OP_APPEND, 0, 32'h7fff_ffff));
		send_command(make_cmd(OP_FRONT, 0, 32'h0));
		// insert at the count lands at the back
		send_command(make_cmd(OP_INSERT, 3, 32'hffff_ffff));
		send_command(make_cmd(OP_INSERT, 2, 32'h1234_5678));
		for (int i = 0; i < 5; i++) begin
			send_command(make_cmd(OP_READ, i, 32'h0));
		end
		send_command(make_cmd(OP_READ, 5, 32'h0));
		send_command(make_cmd(OP_READ, 31, 32'h0));
		send_command(make_cmd(OP_WRITE, 4, 32'h0f0f_0f0f));
		send_command(make_cmd(OP_WRITE, 5, 32'h5555_5555));
		send_command(make_cmd(OP_REMOVE, 0, 32'h0));
		send_command(make_cmd(OP_REMOVE, 3, 32'h0));
		send_command(make_cmd(OP_REMOVE, 4, 32'h0));
		// insert past the count
		send_command(make_cmd(OP_INSERT, 4, 32'haaaa_aaaa));
		send_command(make_cmd(OP_UNUSED, 31, 32'hffff_ffff));
		send_command(make_cmd(OP_CLEAR, 0, 32'h0));
	endtask

	// fill to capacity, then every full-list answer and the range-before-full order
	task automatic test_full_list();
		send_command(make_cmd(OP_CLEAR, 0, 32'h0));
		while (shadow_count < CAPACITY) begin
			send_command(make_cmd(random_grow_op(), $urandom_range(shadow_count),
				random_word()));
		end
		send_command(make_cmd(OP_APPEND, 0, random_word()));
		send_command(make_cmd(OP_FRONT, 0, random_word()));
		send_command(make_cmd(OP_INSERT, CAPACITY, random_word()));
		send_command(make_cmd(OP_INSERT, 0, random_word()));
		send_command(make_cmd(OP_INSERT, CAPACITY + 1, random_word()));
		send_command(make_cmd(OP_INSERT, 31, random_word()));
		send_command(make_cmd(OP_READ, CAPACITY - 1, 32'h0));
		send_command(make_cmd(OP_READ, CAPACITY, 32'h0));
		send_command(make_cmd(OP_WRITE, CAPACITY - 1, random_word()));
		send_command(make_cmd(OP_REMOVE, CAPACITY, 32'h0));
		send_command(make_cmd(OP_REMOVE, CAPACITY / 2, 32'h0));
		send_command(make_cmd(OP_APPEND, 0, random_word()));
		send_command(make_cmd(OP_APPEND, 0, random_word()));
		for (int i = 0; i < CAPACITY; i++) begin
			send_command(make_cmd(OP_READ, i, 32'h0));
		end
	endtask

	// random commands in bursts of 40, each burst pushing the list up, down or neither at random
	task automatic run_random_traffic(input int n_cmds);
		int grow_pct;
		grow_pct = 50;
		for (int i = 0; i < n_cmds; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0: grow_pct = 85;
					1: grow_pct = 50;
					default: grow_pct = 15;
				endcase
			end
			send_command(choose_command(grow_pct));
		end
	endtask

	task automatic test_back_to_back();
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		run_random_traffic(200);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 80;
		rcv_stall_pct = 0;
		run_random_traffic(150);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		rcv_stall_pct = 80;
		run_random_traffic(75);
		// the sender holds off until the engine has answered everything
		wait_for_responses();
		run_random_traffic(75);
	endtask

	task automatic test_mixed_idling();
		send_idle_pct = 11;
		rcv_stall_pct = 11;
		run_random_traffic(250);
	endtask

	initial begin
		for (int i = 0; i < CAPACITY; i++) begin
			shadow_words[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_for_responses();
		test_full_list();
		wait_for_responses();
		test_back_to_back();
		wait_for_responses();
		test_sender_gaps();
		wait_for_responses();
		test_receiver_stalls();
		wait_for_responses();
		test_mixed_idling();
		wait_for_responses();
		// wait on with the receiver ready to catch any stray response
		rcv_stall_pct = 0;
		repeat (10) @(posedge clk);
		if (error_count == 0 && owed_rsps.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
